// ===== rtl/lcdn_pkg.sv =====
// Shared types, microcode control word and constants for the character LCD nibble interface.
`timescale 1ns / 1ps
package lcdn_pkg;

    // Request codes carried on the input channel.
    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_DATA = 2'd1,
        REQ_SLOW = 2'd2,
        REQ_INIT = 2'd3
    } lcdn_req_t;

    // Source of the data lines for one step.
    typedef enum logic [1:0] {
        NIB_KEEP  = 2'd0,
        NIB_CONST = 2'd1,
        NIB_HI    = 2'd2,
        NIB_LO    = 2'd3
    } lcdn_nib_sel_t;

    // Source of the register select level for one step.
    typedef enum logic [1:0] {
        RS_KEEP = 2'd0,
        RS_ZERO = 2'd1,
        RS_REQ  = 2'd2
    } lcdn_rs_sel_t;

    // Hold time choice for one step.
    typedef enum logic [2:0] {
        HOLD_ONE      = 3'd0,
        HOLD_BYTE_END = 3'd1,
        HOLD_POWER    = 3'd2,
        HOLD_WAKE0    = 3'd3,
        HOLD_WAKE1    = 3'd4,
        HOLD_WAKE2    = 3'd5
    } lcdn_hold_sel_t;

    // Sequencing after a step.
    typedef enum logic {
        JMP_NEXT = 1'b0,
        JMP_LOOP = 1'b1
    } lcdn_jmp_t;

    // One microcode control word.
    typedef struct packed {
        lcdn_rs_sel_t   rs_sel;
        lcdn_nib_sel_t  nib_sel;
        logic [3:0]     nib_const;
        logic           enable;
        lcdn_hold_sel_t hold_sel;
        lcdn_jmp_t      jmp;
    } lcdn_ctl_t;

    // Per-request operand information handed to the datapath.
    typedef struct packed {
        logic [7:0] operand;
        logic       rs_req;
        logic       slow;
        logic       last;
    } lcdn_op_t;

    localparam int PC_W = 4;
    localparam int CMD_IDX_W = 3;

    localparam logic [PC_W-1:0] INIT_ENTRY = 4'd0;
    localparam logic [PC_W-1:0] BYTE_ENTRY = 4'd9;

    localparam logic [CMD_IDX_W-1:0] CMD_IDX_CLEAR = 3'd2;
    localparam logic [CMD_IDX_W-1:0] CMD_IDX_ATTR  = 3'd4;

    localparam logic [7:0] CMD_FUNCSET = 8'h28;
    localparam logic [7:0] CMD_DISPOFF = 8'h08;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_ENTRY   = 8'h06;

    localparam logic [7:0] ATTR_RESET = 8'd12;

    localparam logic [15:0] HOLD_VAL_ONE   = 16'd1;
    localparam logic [15:0] HOLD_VAL_BYTE  = 16'd41;
    localparam logic [15:0] HOLD_VAL_SLOW  = 16'd2041;
    localparam logic [15:0] HOLD_VAL_POWER = 16'd50000;
    localparam logic [15:0] HOLD_VAL_WAKE0 = 16'd5001;
    localparam logic [15:0] HOLD_VAL_WAKE1 = 16'd111;
    localparam logic [15:0] HOLD_VAL_WAKE2 = 16'd41;

    // Fixed initialisation commands; the display attribute comes from its register.
    function automatic logic [7:0] init_cmd(input logic [CMD_IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CMD_FUNCSET;
            3'd1:    c = CMD_DISPOFF;
            3'd2:    c = CMD_CLEAR;
            3'd3:    c = CMD_ENTRY;
            default: c = CMD_FUNCSET;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/lcdn_ucode_rom.sv =====
// Microcode program store: one control word per sequencer step.
`timescale 1ns / 1ps
module lcdn_ucode_rom
    import lcdn_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output lcdn_ctl_t       ctl
);

    // Steps 0 to 8 are the power-up wait and wake-up nibbles; 9 to 12 send one byte.
    always_comb begin
        unique case (pc)
            4'd0:  ctl = '{RS_KEEP, NIB_KEEP,  4'h0, 1'b0, HOLD_POWER,    JMP_NEXT};
            4'd1:  ctl = '{RS_ZERO, NIB_CONST, 4'h3, 1'b1, HOLD_ONE,      JMP_NEXT};
            4'd2:  ctl = '{RS_KEEP, NIB_KEEP,  4'h0, 1'b0, HOLD_WAKE0,    JMP_NEXT};
            4'd3:  ctl = '{RS_KEEP, NIB_CONST, 4'h3, 1'b1, HOLD_ONE,      JMP_NEXT};
            4'd4:  ctl = '{RS_KEEP, NIB_KEEP,  4'h0, 1'b0, HOLD_WAKE1,    JMP_NEXT};
            4'd5:  ctl = '{RS_KEEP, NIB_CONST, 4'h3, 1'b1, HOLD_ONE,      JMP_NEXT};
            4'd6:  ctl = '{RS_KEEP, NIB_KEEP,  4'h0, 1'b0, HOLD_WAKE2,    JMP_NEXT};
            4'd7:  ctl = '{RS_KEEP, NIB_CONST, 4'h2, 1'b1, HOLD_ONE,      JMP_NEXT};
            4'd8:  ctl = '{RS_KEEP, NIB_KEEP,  4'h0, 1'b0, HOLD_ONE,      JMP_NEXT};
            4'd9:  ctl = '{RS_REQ,  NIB_HI,    4'h0, 1'b1, HOLD_ONE,      JMP_NEXT};
            4'd10: ctl = '{RS_KEEP, NIB_KEEP,  4'h0, 1'b0, HOLD_ONE,      JMP_NEXT};
            4'd11: ctl = '{RS_KEEP, NIB_LO,    4'h0, 1'b1, HOLD_ONE,      JMP_NEXT};
            4'd12: ctl = '{RS_KEEP, NIB_KEEP,  4'h0, 1'b0, HOLD_BYTE_END, JMP_LOOP};
            default: ctl = '{RS_KEEP, NIB_KEEP, 4'h0, 1'b0, HOLD_BYTE_END, JMP_LOOP};
        endcase
    end

endmodule

// ===== rtl/lcdn_datapath.sv =====
// Pin-level datapath: RS and bus level registers, hold time selection and output register.
`timescale 1ns / 1ps
module lcdn_datapath
    import lcdn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_fire,
    input  lcdn_ctl_t   ctl,
    input  lcdn_op_t    op,
    input  logic        m_ready,
    output logic        m_valid,
    output logic        m_rs_pin,
    output logic        m_enable_pin,
    output logic [3:0]  m_data_lines,
    output logic [15:0] m_hold_us,
    output logic        m_last
);

    logic        rs_level_reg, rs_level_next;
    logic [3:0]  bus_level_reg, bus_level_next;
    logic        m_valid_reg;
    logic        rs_pin_reg, enable_pin_reg, last_reg;
    logic [3:0]  data_lines_reg;
    logic [15:0] hold_us_reg, hold_next;

    // Register select level for this step.
    always_comb begin
        unique case (ctl.rs_sel)
            RS_ZERO: rs_level_next = 1'b0;
            RS_REQ:  rs_level_next = op.rs_req;
            default: rs_level_next = rs_level_reg;
        endcase
    end

    // Data line levels for this step.
    always_comb begin
        unique case (ctl.nib_sel)
            NIB_CONST: bus_level_next = ctl.nib_const;
            NIB_HI:    bus_level_next = op.operand[7:4];
            NIB_LO:    bus_level_next = op.operand[3:0];
            default:   bus_level_next = bus_level_reg;
        endcase
    end

    // Hold time; the closing state of a slow command carries the long wait.
    always_comb begin
        unique case (ctl.hold_sel)
            HOLD_BYTE_END: hold_next = op.slow ? HOLD_VAL_SLOW : HOLD_VAL_BYTE;
            HOLD_POWER:    hold_next = HOLD_VAL_POWER;
            HOLD_WAKE0:    hold_next = HOLD_VAL_WAKE0;
            HOLD_WAKE1:    hold_next = HOLD_VAL_WAKE1;
            HOLD_WAKE2:    hold_next = HOLD_VAL_WAKE2;
            default:       hold_next = HOLD_VAL_ONE;
        endcase
    end

    // Pin level state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_level_reg  <= 1'b0;
            bus_level_reg <= 4'd0;
        end else if (step_fire) begin
            rs_level_reg  <= rs_level_next;
            bus_level_reg <= bus_level_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (step_fire) begin
            rs_pin_reg     <= rs_level_next;
            enable_pin_reg <= ctl.enable;
            data_lines_reg <= bus_level_next;
            hold_us_reg    <= hold_next;
            last_reg       <= op.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rs_pin     = rs_pin_reg;
    assign m_enable_pin = enable_pin_reg;
    assign m_data_lines = data_lines_reg;
    assign m_hold_us    = hold_us_reg;
    assign m_last       = last_reg;

endmodule

// ===== rtl/char_lcd_nibble_interface_top.sv =====
// Top level: request intake, microcode sequencer, configuration port and assertions.
// The first pin state of a request is loaded into the output register by the first step after it is taken.
// The sequencer loads one pin state per cycle while the sink is ready; a byte request gives 4 states
// and initialisation 29.
// The next request can be taken in the cycle after the final state of the current one is loaded.
// Synchronous active-low reset clears the sequencer, pin levels and sets display_attr to 12.
`timescale 1ns / 1ps
module char_lcd_nibble_interface_top
    import lcdn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_byte_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_rs_pin,
    output logic        m_enable_pin,
    output logic [3:0]  m_data_lines,
    output logic [15:0] m_hold_us,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 busy_reg;
    logic [PC_W-1:0]      pc_reg;
    logic [CMD_IDX_W-1:0] cmd_idx_reg;
    logic                 init_reg;
    lcdn_req_t            req_type_reg;
    logic [7:0]           byte_reg;
    logic [7:0]           display_attr_reg;
    lcdn_ctl_t            ctl;
    lcdn_op_t             op;
    logic                 more_cmds;
    logic                 step_fire;
    logic                 s_fire;
    logic                 cfg_write;

    // Configuration register; only the first word address decodes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_attr_reg <= ATTR_RESET;
        end else if (cfg_write && !paddr[2]) begin
            display_attr_reg <= pwdata[7:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {24'd0, display_attr_reg};

    // Handshakes: while busy, a step runs whenever the output register is free or draining.
    assign s_ready   = !busy_reg;
    assign s_fire    = s_valid && s_ready;
    assign step_fire = busy_reg && (!m_valid || m_ready);

    // Operand for the byte steps and the end-of-program test.
    assign more_cmds = init_reg && (cmd_idx_reg != CMD_IDX_ATTR);

    always_comb begin
        op.operand = byte_reg;
        if (init_reg) begin
            op.operand = (cmd_idx_reg == CMD_IDX_ATTR) ? display_attr_reg
                                                       : init_cmd(cmd_idx_reg);
        end
        op.rs_req = !init_reg && (req_type_reg == REQ_DATA);
        op.slow   = init_reg ? (cmd_idx_reg == CMD_IDX_CLEAR) : (req_type_reg == REQ_SLOW);
        op.last   = (ctl.jmp == JMP_LOOP) && !more_cmds;
    end

    // Request capture.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_type_reg <= lcdn_req_t'(s_req_type);
            byte_reg     <= s_byte_value;
        end
    end

    // Step counter with the byte loop back-jump.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= INIT_ENTRY;
            cmd_idx_reg <= '0;
            init_reg    <= 1'b0;
        end else if (s_fire) begin
            busy_reg    <= 1'b1;
            init_reg    <= (s_req_type == REQ_INIT);
            pc_reg      <= (s_req_type == REQ_INIT) ? INIT_ENTRY : BYTE_ENTRY;
            cmd_idx_reg <= '0;
        end else if (step_fire) begin
            unique case (ctl.jmp)
                JMP_LOOP: begin
                    if (more_cmds) begin
                        pc_reg      <= BYTE_ENTRY;
                        cmd_idx_reg <= cmd_idx_reg + 3'd1;
                    end else begin
                        busy_reg <= 1'b0;
                    end
                end
                default: begin
                    pc_reg <= pc_reg + 4'd1;
                end
            endcase
        end
    end

    lcdn_ucode_rom u_rom (
        .pc  (pc_reg),
        .ctl (ctl)
    );

    lcdn_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_fire    (step_fire),
        .ctl          (ctl),
        .op           (op),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_rs_pin     (m_rs_pin),
        .m_enable_pin (m_enable_pin),
        .m_data_lines (m_data_lines),
        .m_hold_us    (m_hold_us),
        .m_last       (m_last)
    );

`ifndef NO_ASSERTIONS
    // An enable pulse state is always held for exactly one microsecond.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_enable_pin |-> m_hold_us == 16'd1)
        else $error("enable-high state with a hold other than 1 us");

    // The sequencer never runs beyond the end of its program.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pc_reg <= 4'd12)
        else $error("step counter outside the microprogram");

    // The initialisation command index stays within its list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cmd_idx_reg <= CMD_IDX_ATTR)
        else $error("command index beyond the initialisation list");

    // Loading the final state of a request frees the sequencer for the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && op.last |=> !busy_reg && m_valid && m_last)
        else $error("final state did not end the request");
`endif

endmodule
